/* hw/rtl/sscd_pkg.sv */
// Package for the scanned seven-segment clock driver.
// Holds the item and scan-word types, the segment table and the sizing constants.
// No dependencies.
`default_nettype none

package sscd_pkg;

    // Display mode toggles when the tick count is a multiple of this period.
    localparam int unsigned MODE_PERIOD = 50;

    // Remainder register width for the tick-count reduction.
    localparam int unsigned MOD_W = $clog2(2 * MODE_PERIOD);
    localparam int unsigned TICK_W = 32;
    localparam int unsigned MOD_BITS_PER_CYCLE = 4;
    localparam int unsigned MOD_CYCLES = TICK_W / MOD_BITS_PER_CYCLE;
    localparam int unsigned MOD_CNT_W = $clog2(MOD_CYCLES);

    // Reciprocal of ten for 16-bit operands: q = (x * DIV10_MUL) >> DIV10_SHIFT.
    localparam logic [16:0] DIV10_MUL = 17'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    // Scan-word queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEG_BLANK = 8'hff;
    localparam logic [7:0] SEG_DP_MASK = 8'h7f;

    // One input item; first declared member sits in the top bits.
    typedef struct packed {
        logic [13:0] year_value;
        logic [3:0]  month_value;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [4:0]  hour_value;
        logic [5:0]  minute_value;
        logic [5:0]  second_value;
        logic [9:0]  millisecond;
        logic [15:0] number_value;
        logic [31:0] tick_count;
    } scan_item_t;

    localparam int unsigned ITEM_W = $bits(scan_item_t);
    localparam int unsigned S_TDATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = 8;

    // The two 16-bit chain words for one scan tick.
    typedef struct packed {
        logic [15:0] small_word;
        logic [15:0] large_word;
    } scan_word_t;

    localparam int unsigned WORD_BITS = 16;
    localparam int unsigned BIT_CNT_W = $clog2(WORD_BITS);

    // Active-low segment pattern for a decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sscd_front.sv */
// Front end: accepts scan ticks, builds the chain words, refills the frame stores.
// Uses sscd_pkg (item/word types, segment table, mode period).
`default_nettype none

module sscd_front import sscd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire scan_item_t item,
    output logic            push_valid,
    input  wire logic       push_ready,
    output scan_word_t      push_word
);

    typedef enum logic [1:0] {F_IDLE, F_MOD, F_STEP} front_state_t;

    typedef enum logic [3:0] {
        SRC_NONE, SRC_CHAIN, SRC_MS, SRC_SEC, SRC_MIN, SRC_HOUR,
        SRC_DAY, SRC_MONTH, SRC_YEAR, SRC_NUM
    } src_t;

    localparam logic [1:0] MODE_TIME  = 2'd0;
    localparam logic [1:0] MODE_DATE  = 2'd1;
    localparam logic [1:0] MODE_UNSET = 2'd2;

    localparam logic [3:0] FIRST_SMALL_STEP = 4'd9;
    localparam logic [3:0] LAST_STEP        = 4'd12;

    front_state_t   state_reg;
    logic [7:0]     large_frame_reg [8];
    logic [7:0]     small_frame_reg [4];
    logic [2:0]     large_idx_reg;
    logic [1:0]     small_idx_reg;
    logic [1:0]     mode_reg;
    logic           large_en_reg;
    logic [3:0]     step_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [TICK_W-1:0]    tick_sh_reg;
    logic [15:0]    cur_reg;
    scan_item_t     item_reg;

    logic           accept;
    logic [7:0]     large_sel;
    logic [7:0]     small_sel;

    assign s_tready   = (state_reg == F_IDLE) && push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = accept;
    assign large_sel  = 8'b1 << large_idx_reg;
    assign small_sel  = 8'b1 << small_idx_reg;
    assign push_word.large_word = {large_frame_reg[large_idx_reg], large_sel};
    assign push_word.small_word = {small_frame_reg[small_idx_reg], small_sel};

    // Tick count reduction, four bits per cycle, MSB first.
    logic [MOD_W-1:0] rem_v;
    always_comb begin
        rem_v = rem_reg;
        for (int j = 0; j < MOD_BITS_PER_CYCLE; j++) begin
            rem_v = (rem_v << 1) | MOD_W'(tick_sh_reg[TICK_W-1-j]);
            if (rem_v >= MOD_W'(MODE_PERIOD)) begin
                rem_v = rem_v - MOD_W'(MODE_PERIOD);
            end
        end
    end

    logic [1:0] mode_new;
    always_comb begin
        mode_new = mode_reg;
        if (rem_v == '0) begin
            mode_new = (mode_reg != MODE_TIME) ? MODE_TIME : MODE_DATE;
        end
    end

    // Refill program: one decimal digit per step.
    src_t       src;
    logic       large_wr;
    logic [2:0] large_dst;
    logic       dot;
    logic       small_wr;
    logic [1:0] small_dst;
    logic       date_mode;

    assign date_mode = (mode_reg == MODE_DATE);

    always_comb begin
        src       = SRC_CHAIN;
        large_wr  = 1'b0;
        large_dst = 3'd0;
        dot       = 1'b0;
        small_wr  = 1'b0;
        small_dst = 2'd0;
        case (step_reg)
            4'd0: begin
                src = date_mode ? SRC_NONE : SRC_MS;
            end
            4'd1: begin
                src = date_mode ? SRC_NONE : SRC_CHAIN;
                large_wr = !date_mode; large_dst = 3'd0;
            end
            4'd2: begin
                src = date_mode ? SRC_NONE : SRC_CHAIN;
                large_wr = !date_mode; large_dst = 3'd1;
            end
            4'd3: begin
                src = date_mode ? SRC_DAY : SRC_SEC;
                large_wr = 1'b1; large_dst = 3'd2; dot = !date_mode;
            end
            4'd4: begin large_wr = 1'b1; large_dst = 3'd3; end
            4'd5: begin
                src = date_mode ? SRC_MONTH : SRC_MIN;
                large_wr = 1'b1; large_dst = 3'd4;
            end
            4'd6: begin large_wr = 1'b1; large_dst = 3'd5; end
            4'd7: begin
                src = date_mode ? SRC_YEAR : SRC_HOUR;
                large_wr = 1'b1; large_dst = 3'd6;
            end
            4'd8: begin large_wr = 1'b1; large_dst = 3'd7; end
            4'd9: begin src = SRC_NUM; small_wr = 1'b1; small_dst = 2'd0; end
            4'd10: begin small_wr = 1'b1; small_dst = 2'd1; end
            4'd11: begin small_wr = 1'b1; small_dst = 2'd2; end
            4'd12: begin small_wr = 1'b1; small_dst = 2'd3; end
            default: begin src = SRC_NONE; end
        endcase
    end

    logic [15:0] operand;
    always_comb begin
        case (src)
            SRC_CHAIN: operand = cur_reg;
            SRC_MS:    operand = 16'(item_reg.millisecond);
            SRC_SEC:   operand = 16'(item_reg.second_value);
            SRC_MIN:   operand = 16'(item_reg.minute_value);
            SRC_HOUR:  operand = 16'(item_reg.hour_value);
            SRC_DAY:   operand = 16'(item_reg.day_of_month);
            SRC_MONTH: operand = 16'(item_reg.month_value);
            SRC_YEAR:  operand = 16'(item_reg.year_value);
            SRC_NUM:   operand = item_reg.number_value;
            default:   operand = '0;
        endcase
    end

    // Divide by ten through the reciprocal, remainder by shift-add back.
    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [3:0]  digit;
    logic [7:0]  code;

    assign prod     = 33'(operand) * 33'(DIV10_MUL);
    assign quot     = 16'(prod[32:DIV10_SHIFT]);
    assign quot_x10 = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
    assign digit    = 4'(operand - quot_x10);
    assign code     = seg_code(digit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            large_idx_reg <= '0;
            small_idx_reg <= '0;
            mode_reg      <= MODE_UNSET;
            large_en_reg  <= 1'b0;
            step_reg      <= '0;
            mod_cnt_reg   <= '0;
            for (int i = 0; i < 8; i++) begin
                large_frame_reg[i] <= SEG_BLANK;
            end
            for (int i = 0; i < 4; i++) begin
                small_frame_reg[i] <= SEG_BLANK;
            end
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        item_reg      <= item;
                        large_idx_reg <= large_idx_reg + 3'd1;
                        small_idx_reg <= small_idx_reg + 2'd1;
                        if (large_idx_reg == 3'd7) begin
                            state_reg   <= F_MOD;
                            mod_cnt_reg <= '0;
                            rem_reg     <= '0;
                            tick_sh_reg <= item.tick_count;
                        end else if (small_idx_reg == 2'd3) begin
                            state_reg <= F_STEP;
                            step_reg  <= FIRST_SMALL_STEP;
                        end
                    end
                end
                F_MOD: begin
                    rem_reg     <= rem_v;
                    tick_sh_reg <= tick_sh_reg << MOD_BITS_PER_CYCLE;
                    mod_cnt_reg <= mod_cnt_reg + 1'b1;
                    if (mod_cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                        mode_reg     <= mode_new;
                        large_en_reg <= (mode_new == MODE_TIME) || (mode_new == MODE_DATE);
                        state_reg    <= F_STEP;
                        step_reg     <= '0;
                    end
                end
                F_STEP: begin
                    cur_reg <= quot;
                    if (large_en_reg && large_wr) begin
                        large_frame_reg[large_dst] <= dot ? (code & SEG_DP_MASK) : code;
                    end
                    // Date mode: weekday digit and blank go in directly.
                    if (large_en_reg && date_mode && step_reg == 4'd0) begin
                        large_frame_reg[0] <= seg_code({1'b0, item_reg.weekday});
                        large_frame_reg[1] <= SEG_BLANK;
                    end
                    if (small_wr) begin
                        small_frame_reg[small_dst] <= code;
                    end
                    if (step_reg == LAST_STEP) begin
                        state_reg <= F_IDLE;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sscd_queue.sv */
// Short register queue of scan words between front and back.
// Uses sscd_pkg (scan_word_t, QUEUE_DEPTH).
`default_nettype none

module sscd_queue import sscd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire scan_word_t push_word,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output scan_word_t      pop_word
);

    scan_word_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                entry_reg[wr_ptr_reg] <= push_word;
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sscd_back.sv */
// Back end: shifts each scan word pair out MSB first, one bit per transfer.
// Uses sscd_pkg (scan_word_t, word size).
`default_nettype none

module sscd_back import sscd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       pop_valid,
    output logic            pop_ready,
    input  wire scan_word_t pop_word,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic            m_tlast
);

    logic                   busy_reg;
    logic [WORD_BITS-1:0]   large_sh_reg;
    logic [WORD_BITS-1:0]   small_sh_reg;
    logic [BIT_CNT_W-1:0]   cnt_reg;
    logic                   last_beat;
    logic                   load;

    assign last_beat = (cnt_reg == BIT_CNT_W'(WORD_BITS - 1));
    assign load      = !busy_reg || (m_tready && last_beat);
    assign pop_ready = load;

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, small_sh_reg[WORD_BITS-1],
                       large_sh_reg[WORD_BITS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= pop_valid;
            cnt_reg  <= '0;
            if (pop_valid) begin
                large_sh_reg <= pop_word.large_word;
                small_sh_reg <= pop_word.small_word;
            end
        end else if (m_tready) begin
            large_sh_reg <= large_sh_reg << 1;
            small_sh_reg <= small_sh_reg << 1;
            cnt_reg      <= cnt_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scanned_seven_segment_clock_driver_top.sv */
// Top level of the scanned seven-segment clock driver.
// Instantiates sscd_front, sscd_queue and sscd_back; uses sscd_pkg.
//
// Usage:
//   s_* channel: one scan tick per transfer, carrying the clock, date, tick
//   count and the number for the four-digit display.
//   m_* channel: sixteen transfers per tick. m_tdata[0] is the bit for the
//   eight-digit chain, m_tdata[1] the bit for the four-digit chain, MSB first
//   (segment byte, then one-hot digit select). m_tlast marks the sixteenth
//   bit, after which the chains are latched.
// Path: each tick's word passes the queue register, then the shift registers.
// Throughput: set by the serializer, one bit per cycle while m_tready is high.
//   The front takes no tick while it refills: the small digits when the small
//   frame wraps, the tick-count remainder and then all digit steps when the
//   large frame wraps; the two-entry word queue absorbs this.
// Reset: both frames go blank, digit indices to zero, display mode undecided
//   until the first toggle, which selects time.
// Stall: while m_tready is low the current bit holds; the front keeps taking
//   ticks until the queue is full, then drops s_tready.
`default_nettype none

module scanned_seven_segment_clock_driver_top import sscd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata, low bit up: tick_count[31:0], number_value[47:32],
    // millisecond[57:48], second_value[63:58], minute_value[69:64],
    // hour_value[74:70], weekday[77:75], day_of_month[82:78],
    // month_value[86:83], year_value[100:87], zero fill [103:101]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, low bit up: serial_bit_large[0], serial_bit_small[1], zero fill
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    // m_tlast: latch_now
    output logic                      m_tlast
);

    scan_item_t item;
    scan_word_t push_word;
    scan_word_t pop_word;
    logic       push_valid;
    logic       push_ready;
    logic       pop_valid;
    logic       pop_ready;

    assign item = scan_item_t'(s_tdata[ITEM_W-1:0]);

    sscd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    sscd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    sscd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/sscd_checker.sv */
// Port-level checker for the scanned seven-segment clock driver, with its bind.
// Uses sscd_pkg (widths); bound to scanned_seven_segment_clock_driver_top.
`default_nettype none

module sscd_checker import sscd_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    logic [BIT_CNT_W-1:0] beat_reg;
    logic [2:0]           open_reg;
    logic                 in_xfer;
    logic                 out_end;

    assign in_xfer = s_tvalid && s_tready;
    assign out_end = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= '0;
            open_reg <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                beat_reg <= beat_reg + 1'b1;
            end
            case ({in_xfer, out_end})
                2'b10:   open_reg <= open_reg + 3'd1;
                2'b01:   open_reg <= open_reg - 3'd1;
                default: open_reg <= open_reg;
            endcase
        end
    end

    // Stalled output holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Reset empties the output side.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Latch mark on every sixteenth bit only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (beat_reg == BIT_CNT_W'(WORD_BITS - 1))))
        else $error("latch mark out of place");

    // No output without a tick in flight; queue plus serializer bound it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (open_reg == 3'd0) |-> !m_tvalid)
        else $error("output with no tick outstanding");

    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 3'(QUEUE_DEPTH + 1))
        else $error("more ticks outstanding than storage allows");

endmodule

bind scanned_seven_segment_clock_driver_top sscd_checker u_sscd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
